// File: hw/rtl/hsfc_pkg.sv
// Shared types and constants for the half/single float converter.
// Holds the request and response structs, status codes and the class codes
// passed from the decode stage into the pipeline. No dependencies.
package hsfc_pkg;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_FINITE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW   = 2'd2;

  localparam logic [7:0]  SGL_EXP_MAX    = 8'hff;
  localparam logic [7:0]  SGL_EXP_BIG    = 8'd142;
  localparam logic [7:0]  SGL_EXP_NORM   = 8'd113;
  localparam logic [7:0]  SGL_EXP_SUB    = 8'd103;
  localparam logic [7:0]  SGL_SUB_SHIFT  = 8'd126;
  localparam logic [7:0]  EXP_BIAS_DIFF  = 8'd112;
  localparam logic [7:0]  HALF_SUB_EXP   = 8'd113;
  localparam logic [4:0]  HALF_EXP_MAX   = 5'd31;
  localparam logic [23:0] ROUND_HALF     = 24'h000fff;
  localparam logic [14:0] HALF_INF       = 15'h7c00;

  typedef enum logic [2:0] {
    K_ZERO,
    K_W_SUB,
    K_W_NORM,
    K_W_INF,
    K_N_NAN,
    K_N_BIG,
    K_N_NORM,
    K_N_SUB
  } hsfc_kind_t;

  typedef struct packed {
    logic        action;
    logic [31:0] operand;
  } hsfc_req_t;

  typedef struct packed {
    logic [31:0] result;
    logic [1:0]  status;
  } hsfc_rsp_t;

  typedef struct packed {
    hsfc_kind_t  kind;
    logic        action;
    logic        sign;
    logic [3:0]  lz_shift;
    logic [4:0]  hexp;
    logic [9:0]  hfrac;
    logic [7:0]  efield;
    logic [22:0] mant;
    logic [4:0]  sh;
    logic [9:0]  quot;
    logic [22:0] rem;
  } hsfc_dec_t;

endpackage

// File: hw/rtl/hsfc_decode.sv
// First pipeline stage logic of the half/single float converter: classifies
// the operand, finds the normalizing shift of a half subnormal and aligns a
// single that narrows to a half subnormal. Depends on hsfc_pkg.
module hsfc_decode
  import hsfc_pkg::*;
(
  input  hsfc_req_t request,
  output hsfc_dec_t dec
);

  logic [15:0] half;
  logic [23:0] full;
  logic [23:0] shifted;
  logic [23:0] mask;
  logic [3:0]  lz;
  logic [7:0]  sh_wide;

  always_comb begin
    half    = request.operand[15:0];
    full    = {1'b1, request.operand[22:0]};
    sh_wide = SGL_SUB_SHIFT - request.operand[30:23];
    shifted = full >> sh_wide[4:0];
    mask    = (24'd1 << sh_wide[4:0]) - 24'd1;

    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (half[i]) begin
        lz = 4'(10 - i);
      end
    end

    dec.action   = request.action;
    dec.sign     = request.action ? request.operand[31] : half[15];
    dec.lz_shift = lz;
    dec.hexp     = half[14:10];
    dec.hfrac    = half[9:0];
    dec.efield   = request.operand[30:23];
    dec.mant     = request.operand[22:0];
    dec.sh       = sh_wide[4:0];
    dec.quot     = shifted[9:0];
    dec.rem      = 23'(full & mask);

    if (!request.action) begin
      if (dec.hexp == 5'd0) begin
        dec.kind = (dec.hfrac == 10'd0) ? K_ZERO : K_W_SUB;
      end else if (dec.hexp == HALF_EXP_MAX) begin
        dec.kind = K_W_INF;
      end else begin
        dec.kind = K_W_NORM;
      end
    end else begin
      if (dec.efield == SGL_EXP_MAX) begin
        dec.kind = K_N_NAN;
      end else if (dec.efield > SGL_EXP_BIG) begin
        dec.kind = K_N_BIG;
      end else if (dec.efield >= SGL_EXP_NORM) begin
        dec.kind = K_N_NORM;
      end else if (dec.efield >= SGL_EXP_SUB) begin
        dec.kind = K_N_SUB;
      end else begin
        dec.kind = K_ZERO;
      end
    end
  end

endmodule

// File: hw/rtl/half_single_float_converter.sv
// Top level of the half/single float converter: a three-stage pipeline of
// decode, round or normalize, and pack with status. Depends on hsfc_pkg and
// hsfc_decode.
//
// A request is taken at each rising edge where start is high and busy is
// low. Busy never rises, so a request may be presented in every cycle and
// the block sustains one conversion per clock.
// The request carries action (0 widens the low 16 bits of operand from half
// to single, 1 narrows all 32 bits from single to half) and the operand.
// Each response shows on the response port for exactly one cycle with done
// high. It is registered through the decode register, the round register
// and the response register in turn: decode with the alignment shift,
// then the rounding add, then the overflow check and pack.
// Responses leave in request order. The receiver cannot stall, so no
// response is ever held back.
// A half result sits in the low 16 bits of result with the upper bits zero.
// Status is ok, not finite, or overflow; in the last case result is zero.
// Synchronous reset clears the valid bits of all stages, dropping any
// conversions in flight; done is low after reset.
module half_single_float_converter
  import hsfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  hsfc_req_t request,
  output logic      done,
  output hsfc_rsp_t response
);

  hsfc_dec_t dec;
  hsfc_dec_t s1;
  logic      s1_valid;

  hsfc_kind_t  s2_kind;
  logic        s2_sign;
  logic [31:0] s2_value;
  logic        s2_valid;

  logic [31:0] s2_value_next;
  hsfc_rsp_t   response_next;

  logic [10:0] norm;
  logic [7:0]  sub_exp;
  logic [23:0] rounded;
  logic [7:0]  hexp_wide;
  logic [14:0] hnorm;
  logic [23:0] mid;
  logic        up;
  logic [10:0] qround;

  assign busy = 1'b0;

  hsfc_decode u_decode (
    .request(request),
    .dec    (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1 <= dec;
  end

  always_comb begin
    norm      = {1'b0, s1.hfrac} << s1.lz_shift;
    sub_exp   = HALF_SUB_EXP - {4'd0, s1.lz_shift};
    rounded   = {1'b0, s1.mant} + ROUND_HALF + {23'd0, s1.mant[13]};
    hexp_wide = s1.efield - EXP_BIAS_DIFF;
    hnorm     = {hexp_wide[4:0], 10'd0} + {4'd0, rounded[23:13]};
    mid       = 24'd1 << (s1.sh - 5'd1);
    up        = ({1'b0, s1.rem} > mid) || (({1'b0, s1.rem} == mid) && s1.quot[0]);
    qround    = {1'b0, s1.quot} + {10'd0, up};

    case (s1.kind)
      K_ZERO:   s2_value_next = s1.action ? {16'd0, s1.sign, 15'd0} : {s1.sign, 31'd0};
      K_W_SUB:  s2_value_next = {s1.sign, sub_exp, norm[9:0], 13'd0};
      K_W_NORM: s2_value_next = {s1.sign, {3'd0, s1.hexp} + EXP_BIAS_DIFF, s1.hfrac, 13'd0};
      K_W_INF:  s2_value_next = {s1.sign, SGL_EXP_MAX, s1.hfrac, 13'd0};
      K_N_NORM: s2_value_next = {17'd0, hnorm};
      K_N_SUB:  s2_value_next = {16'd0, s1.sign, 4'd0, qround};
      default:  s2_value_next = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_kind  <= s1.kind;
    s2_sign  <= s1.sign;
    s2_value <= s2_value_next;
  end

  always_comb begin
    response_next.result = s2_value;
    response_next.status = ST_OK;
    case (s2_kind)
      K_W_INF: response_next.status = ST_NOT_FINITE;
      K_N_NAN: response_next.status = ST_NOT_FINITE;
      K_N_BIG: response_next.status = ST_OVERFLOW;
      K_N_NORM: begin
        if (s2_value[14:0] >= HALF_INF) begin
          response_next.status = ST_OVERFLOW;
          response_next.result = 32'd0;
        end else begin
          response_next.result = {16'd0, s2_sign, s2_value[14:0]};
        end
      end
      default: response_next.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
    response <= response_next;
  end

  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("response without a matching request");

  a_request_gets_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("request lost in the pipeline");

  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    (done && response.status == ST_OVERFLOW) |-> (response.result == 32'd0))
    else $error("overflow response with nonzero result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (response.status == ST_OK || response.status == ST_NOT_FINITE ||
              response.status == ST_OVERFLOW))
    else $error("undefined status code");

endmodule

// File: tb/tb.sv
// Testbench for half_single_float_converter: directed and random conversion requests
// checked against fixed expected values or a behavioral model of the half/single IEEE 754 conversions.
// Depends on hsfc_pkg and the converter RTL.
module tb;
  import hsfc_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned NUM_RANDOM = 550;
  localparam int unsigned NUM_DIRECTED = 25;

  typedef struct {
    logic        action;
    logic [31:0] operand;
    bit          fixed;
    hsfc_rsp_t   rsp;
  } conv_case_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  hsfc_req_t request = '0;
  logic      done;
  hsfc_rsp_t response;

  hsfc_rsp_t   pending_rsp[$];
  int unsigned fail_count = 0;
  int unsigned idle_count = 0;
  int unsigned burst_left = 0;

  conv_case_t directed_cases [NUM_DIRECTED] = '{
    '{1'b0, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK}},
    '{1'b0, 32'h0000_8000, 1'b1, '{32'h8000_0000, ST_OK}},
    '{1'b0, 32'h0000_0001, 1'b0, '{32'h0, ST_OK}},
    '{1'b0, 32'h0000_83ff, 1'b0, '{32'h0, ST_OK}},
    '{1'b0, 32'h0000_3c00, 1'b1, '{32'h3f80_0000, ST_OK}},
    '{1'b0, 32'h0000_fbff, 1'b0, '{32'h0, ST_OK}},
    '{1'b0, 32'h0000_7c00, 1'b1, '{32'h7f80_0000, ST_NOT_FINITE}},
    '{1'b0, 32'h0000_fe00, 1'b1, '{32'hffc0_0000, ST_NOT_FINITE}},
    '{1'b0, 32'hffff_3c00, 1'b1, '{32'h3f80_0000, ST_OK}},
    '{1'b1, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK}},
    '{1'b1, 32'h8000_0000, 1'b1, '{32'h0000_8000, ST_OK}},
    '{1'b1, 32'h7f80_0000, 1'b1, '{32'h0000_0000, ST_NOT_FINITE}},
    '{1'b1, 32'hffc0_0001, 1'b1, '{32'h0000_0000, ST_NOT_FINITE}},
    '{1'b1, 32'h4780_0000, 1'b1, '{32'h0000_0000, ST_OVERFLOW}},
    '{1'b1, 32'h477f_e000, 1'b1, '{32'h0000_7bff, ST_OK}},
    '{1'b1, 32'hc77f_f000, 1'b1, '{32'h0000_0000, ST_OVERFLOW}},
    '{1'b1, 32'h3f80_0000, 1'b1, '{32'h0000_3c00, ST_OK}},
    '{1'b1, 32'h3f80_1000, 1'b0, '{32'h0, ST_OK}},
    '{1'b1, 32'hbf80_3000, 1'b0, '{32'h0, ST_OK}},
    '{1'b1, 32'h3fff_ffff, 1'b0, '{32'h0, ST_OK}},
    '{1'b1, 32'h3880_0000, 1'b1, '{32'h0000_0400, ST_OK}},
    '{1'b1, 32'h3380_0000, 1'b1, '{32'h0000_0001, ST_OK}},
    '{1'b1, 32'hb37f_ffff, 1'b1, '{32'h0000_8000, ST_OK}},
    '{1'b1, 32'h33c0_0000, 1'b0, '{32'h0, ST_OK}},
    '{1'b1, 32'h807f_ffff, 1'b1, '{32'h0000_8000, ST_OK}}
  };

  half_single_float_converter i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .response (response)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic hsfc_rsp_t predict_conversion(hsfc_req_t rq);
    hsfc_rsp_t   rsp;
    logic [10:0] norm;
    logic [7:0]  wexp;
    logic        sgn;
    int          uexp;
    int unsigned rounded, hval, full, sh, quot, rem, mid;
    rsp.result = '0;
    rsp.status = ST_OK;
    if (!rq.action) begin
      sgn = rq.operand[15];
      if (rq.operand[14:10] == 5'd0) begin
        if (rq.operand[9:0] == 10'd0) begin
          rsp.result = {sgn, 31'd0};
        end else begin
          norm = {1'b0, rq.operand[9:0]};
          wexp = 8'd113;
          while (!norm[10]) begin
            norm = norm << 1;
            wexp = wexp - 8'd1;
          end
          rsp.result = {sgn, wexp, norm[9:0], 13'd0};
        end
      end else if (rq.operand[14:10] == 5'h1f) begin
        rsp.status = ST_NOT_FINITE;
        rsp.result = {sgn, 8'hff, rq.operand[9:0], 13'd0};
      end else begin
        wexp = {3'd0, rq.operand[14:10]} + 8'd112;
        rsp.result = {sgn, wexp, rq.operand[9:0], 13'd0};
      end
    end else begin
      sgn = rq.operand[31];
      uexp = int'({24'd0, rq.operand[30:23]}) - 127;
      if (rq.operand[30:23] == 8'hff) begin
        rsp.status = ST_NOT_FINITE;
      end else if (uexp > 15) begin
        rsp.status = ST_OVERFLOW;
      end else if (uexp >= -14) begin
        rounded = {9'd0, rq.operand[22:0]} + 32'h0000_0fff + {31'd0, rq.operand[13]};
        hval = (32'(uexp + 15) << 10) + (rounded >> 13);
        if (hval >= 32'h0000_7c00) begin
          rsp.status = ST_OVERFLOW;
        end else begin
          rsp.result = {16'd0, sgn, hval[14:0]};
        end
      end else if (uexp < -24) begin
        rsp.result = {16'd0, sgn, 15'd0};
      end else begin
        full = {8'd0, 1'b1, rq.operand[22:0]};
        sh = 32'(-1 - uexp);
        quot = full >> sh;
        rem = full & ((32'd1 << sh) - 32'd1);
        mid = 32'd1 << (sh - 32'd1);
        if (rem > mid || (rem == mid && quot[0])) begin
          quot = quot + 32'd1;
        end
        rsp.result = {16'd0, sgn, 15'd0} | quot;
      end
    end
    return rsp;
  endfunction

  task automatic send_request(input hsfc_req_t rq, input hsfc_rsp_t want);
    int unsigned gap;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (pick < 5) begin
      burst_left = $urandom_range(10, 40);
      gap = 0;
    end else if (pick < 50) begin
      gap = 0;
    end else if (pick < 85) begin
      gap = $urandom_range(1, 3);
    end else if (pick < 97) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= rq;
    do @(posedge clk); while (busy);
    pending_rsp = {pending_rsp, want};
  endtask

  always @(posedge clk) begin : check_responses
    hsfc_rsp_t want;
    logic      active;
    active = 1'b0;
    if (!rst && start && !busy) begin
      active = 1'b1;
    end
    if (!rst && done) begin
      active = 1'b1;
      if (pending_rsp.size() == 0) begin
        $error("response with no request pending: result %h status %0d",
               response.result, response.status);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (response.result !== want.result) begin
          $error("result: expected %h, got %h", want.result, response.result);
          fail_count++;
        end
        if (response.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, response.status);
          fail_count++;
        end
      end
    end
    idle_count = active ? 0 : idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("[half_single_float_converter] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    hsfc_req_t   rq;
    hsfc_rsp_t   want;
    int unsigned sel;
    logic [31:0] bits;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_cases[i]) begin
      rq.action = directed_cases[i].action;
      rq.operand = directed_cases[i].operand;
      want = directed_cases[i].fixed ? directed_cases[i].rsp : predict_conversion(rq);
      send_request(rq, want);
    end

    for (int unsigned n = 0; n < NUM_RANDOM; n++) begin
      rq.action = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 9);
      bits = $urandom();
      rq.operand = bits;
      if (sel >= 3) begin
        if (!rq.action) begin
          case (sel)
            3, 4: rq.operand[14:10] = 5'd0;
            5: rq.operand[14:10] = 5'h1f;
            default: rq.operand[14:10] = 5'($urandom_range(1, 30));
          endcase
        end else begin
          case (sel)
            3, 4: rq.operand[30:23] = 8'($urandom_range(98, 145));
            5: rq.operand[30:23] = 8'hff;
            6: rq.operand[30:23] = 8'($urandom_range(0, 97));
            7: begin
              rq.operand[30:23] = 8'd142;
              rq.operand[22:13] = 10'h3ff;
            end
            default: begin
              rq.operand[30:23] = 8'($urandom_range(103, 142));
              rq.operand[12:0] = bits[31] ? 13'h1000 : 13'h0fff;
            end
          endcase
        end
      end
      send_request(rq, predict_conversion(rq));
    end
    start <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[half_single_float_converter] OK");
    end else begin
      $display("[half_single_float_converter] ERROR");
    end
    $finish;
  end

endmodule
